// ----- sv/i2cmwr_pkg.sv -----
package i2cmwr_pkg;

    // Data bytes held in the frame buffer; the address byte sits in front of them.
    localparam int BUFFER_BYTES = 16;
    localparam int FRAME_LEN    = BUFFER_BYTES + 1;
    localparam int OFF_W        = $clog2(FRAME_LEN + 1);
    localparam int MEM_AW       = $clog2(BUFFER_BYTES);

    localparam logic [7:0] ST_START        = 8'h08;
    localparam logic [7:0] ST_REP_START    = 8'h10;
    localparam logic [7:0] ST_ARB_LOST     = 8'h38;
    localparam logic [7:0] ST_TX_ADDR_ACK  = 8'h18;
    localparam logic [7:0] ST_TX_DATA_ACK  = 8'h28;
    localparam logic [7:0] ST_RX_ADDR_ACK  = 8'h40;
    localparam logic [7:0] ST_RX_DATA_ACK  = 8'h50;
    localparam logic [7:0] ST_RX_DATA_NACK = 8'h58;
    localparam logic [7:0] IDLE_BYTE       = 8'hFF;

    typedef enum logic [1:0] {
        KIND_LOAD   = 2'd0,
        KIND_START  = 2'd1,
        KIND_STATUS = 2'd2,
        KIND_READ   = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_XFER  = 3'd2,
        CMD_STOP  = 3'd3,
        CMD_ABORT = 3'd4,
        CMD_ACK   = 3'd5,
        CMD_NACK  = 3'd6
    } t_cmd;

    typedef struct packed {
        t_kind      kind;
        logic [3:0] index;
        logic [7:0] data_byte;
        logic [6:0] slave_address;
        logic [7:0] send_count;
        logic [7:0] recv_count;
        logic [7:0] status_code;
    } t_item;

    typedef struct packed {
        logic              we;
        logic [MEM_AW-1:0] waddr;
        logic [7:0]        wdata;
        logic              re;
        logic [MEM_AW-1:0] raddr;
    } t_mem_req;

    typedef struct packed {
        t_cmd             command;
        logic [7:0]       tx_byte;
        logic             tx_valid;
        logic             tx_from_mem;
        logic             done;
        logic             busy;
        logic             rx_from_mem;
        logic [OFF_W-1:0] received_count;
    } t_result;

endpackage

// ----- sv/i2c_master_write_read_sequencer.sv -----
// I2C master write-then-read sequencer.
// An accepted item passes through the input register, then the result register.
// Throughput: one item per cycle unless the result side stalls; the input and the result
// registers decouple the sides: an empty input register takes an item as a result waits.
// Reset (i_rst_n low, synchronous): pipeline empty, offset/totals zero, not busy.
module i2c_master_write_read_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input item channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_kind,
    input  logic [3:0]  i_index,
    input  logic [7:0]  i_data_byte,
    input  logic [6:0]  i_slave_address,
    input  logic [7:0]  i_send_count,
    input  logic [7:0]  i_recv_count,
    input  logic [7:0]  i_status_code,
    // result item channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_command,
    output logic [7:0]  o_tx_byte,
    output logic        o_tx_valid,
    output logic        o_done_res,
    output logic        o_busy_res,
    output logic [7:0]  o_rx_byte,
    output logic [4:0]  o_received_count
);

    // Stage 1: input register. The controller decodes the item against the
    // transaction state and updates that state when the item moves on.
    logic              r_in_valid, n_in_valid;
    i2cmwr_pkg::t_item r_item;

    // Stage 2: result register. Buffer bytes come out of the frame RAM's
    // registered read port, which lines up with this stage.
    logic                r_out_valid, n_out_valid;
    i2cmwr_pkg::t_result r_res;

    logic                 out_free;   // result register empty or being drained
    logic                 fire;       // stage 1 item moves into the result register
    logic                 take;       // input item accepted
    i2cmwr_pkg::t_mem_req mem_req;
    i2cmwr_pkg::t_result  ctrl_res;
    logic [7:0]           mem_q;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign take       = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid  = r_in_valid;
        n_out_valid = r_out_valid;
        if (take) begin
            n_in_valid = 1'b1;
        end else if (fire) begin
            n_in_valid = 1'b0;
        end
        if (fire) begin
            n_out_valid = 1'b1;
        end else if (out_free) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item.kind          <= i2cmwr_pkg::t_kind'(i_kind);
            r_item.index         <= i_index;
            r_item.data_byte     <= i_data_byte;
            r_item.slave_address <= i_slave_address;
            r_item.send_count    <= i_send_count;
            r_item.recv_count    <= i_recv_count;
            r_item.status_code   <= i_status_code;
        end
        if (fire) begin
            r_res <= ctrl_res;
        end
    end

    i2cmwr_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_item    (r_item),
        .o_mem_req (mem_req),
        .o_result  (ctrl_res)
    );

    // data bytes 1..N of the frame; reads only on fire, so q holds under stall
    i2cmwr_frame_buf u_frame_buf (
        .i_clk (i_clk),
        .i_req (mem_req),
        .o_q   (mem_q)
    );

    assign o_out_valid      = r_out_valid;
    assign o_command        = r_res.command;
    assign o_tx_byte        = r_res.tx_from_mem ? mem_q : r_res.tx_byte;
    assign o_tx_valid       = r_res.tx_valid;
    assign o_done_res       = r_res.done;
    assign o_busy_res       = r_res.busy;
    assign o_rx_byte        = r_res.rx_from_mem ? mem_q : 8'h00;
    assign o_received_count = r_res.received_count;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_done_res) |-> !o_busy_res)
        else $error("done pulse while still busy");

    a_stop_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_command == i2cmwr_pkg::CMD_STOP ||
                         o_command == i2cmwr_pkg::CMD_ABORT))
        |-> (o_tx_valid && o_tx_byte == i2cmwr_pkg::IDLE_BYTE && o_done_res))
        else $error("stop/abort without idle byte and done");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && o_out_valid && i_out_stall))
        else $error("input stalled while the result register can drain");

endmodule

// ----- sv/i2cmwr_frame_buf.sv -----
module i2cmwr_frame_buf (
    input  logic                  i_clk,
    input  i2cmwr_pkg::t_mem_req  i_req,
    output logic [7:0]            o_q
);

    logic [7:0] r_mem [i2cmwr_pkg::BUFFER_BYTES];
    logic [7:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_q <= r_mem[i_req.raddr];
        end
    end

    assign o_q = r_q;

endmodule

// ----- sv/i2cmwr_ctrl.sv -----
module i2cmwr_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  i2cmwr_pkg::t_item     i_item,
    output i2cmwr_pkg::t_mem_req  o_mem_req,
    output i2cmwr_pkg::t_result   o_result
);

    localparam int OFF_W = i2cmwr_pkg::OFF_W;
    localparam logic [OFF_W-1:0] FRAME_LEN_C = OFF_W'(i2cmwr_pkg::FRAME_LEN);
    localparam logic [OFF_W-1:0] BUF_C       = OFF_W'(i2cmwr_pkg::BUFFER_BYTES);
    localparam logic [OFF_W-1:0] ONE_C       = OFF_W'(1);

    logic [7:0]       r_addr_byte, n_addr_byte;
    logic [OFF_W-1:0] r_byte_offset, n_byte_offset;
    logic [OFF_W-1:0] r_send_total, n_send_total;
    logic [OFF_W-1:0] r_recv_total, n_recv_total;
    logic             r_busy, n_busy;

    i2cmwr_pkg::t_mem_req req;
    i2cmwr_pkg::t_result  res;

    function automatic logic [OFF_W-1:0] sat_count(input logic [7:0] v);
        logic [OFF_W-1:0] s;
        if (v > 8'(i2cmwr_pkg::BUFFER_BYTES)) begin
            s = BUF_C;
        end else begin
            s = OFF_W'(v);
        end
        return s;
    endfunction

    always_comb begin
        logic             tx_phase;
        logic             rx_phase;
        logic [OFF_W-1:0] off_tx;
        logic [OFF_W-1:0] off_rx;
        logic [OFF_W-1:0] s_cnt;
        logic [OFF_W-1:0] r_cnt;
        logic [OFF_W-1:0] n_cnt;

        n_addr_byte   = r_addr_byte;
        n_byte_offset = r_byte_offset;
        n_send_total  = r_send_total;
        n_recv_total  = r_recv_total;
        n_busy        = r_busy;
        req           = '0;
        res           = '0;
        tx_phase      = 1'b0;
        rx_phase      = 1'b0;
        off_tx        = r_byte_offset;
        off_rx        = r_byte_offset;
        s_cnt         = sat_count(i_item.send_count);
        r_cnt         = sat_count(i_item.recv_count);
        n_cnt         = (r_recv_total < r_cnt) ? r_recv_total : r_cnt;

        unique case (i_item.kind)
            i2cmwr_pkg::KIND_LOAD: begin
                if (!r_busy) begin
                    req.we    = 1'b1;
                    req.waddr = i_item.index;
                    req.wdata = i_item.data_byte;
                end
            end
            i2cmwr_pkg::KIND_START: begin
                if (!r_busy) begin
                    n_addr_byte  = {i_item.slave_address, (s_cnt == '0)};
                    n_send_total = s_cnt + ONE_C;
                    n_recv_total = r_cnt + ONE_C;
                    n_busy       = 1'b1;
                    res.command  = i2cmwr_pkg::CMD_START;
                end
            end
            i2cmwr_pkg::KIND_STATUS: begin
                if (r_busy) begin
                    case (i_item.status_code) inside
                        i2cmwr_pkg::ST_START, i2cmwr_pkg::ST_REP_START: begin
                            off_tx   = '0;
                            tx_phase = 1'b1;
                        end
                        i2cmwr_pkg::ST_TX_ADDR_ACK, i2cmwr_pkg::ST_TX_DATA_ACK: begin
                            tx_phase = 1'b1;
                        end
                        i2cmwr_pkg::ST_ARB_LOST: begin
                            if (r_send_total != ONE_C) begin
                                n_addr_byte = {r_addr_byte[7:1], 1'b0};
                            end
                            res.command = i2cmwr_pkg::CMD_START;
                        end
                        i2cmwr_pkg::ST_RX_DATA_ACK: begin
                            if (r_byte_offset < FRAME_LEN_C) begin
                                if (r_byte_offset == '0) begin
                                    n_addr_byte = i_item.data_byte;
                                end else begin
                                    req.we    = 1'b1;
                                    req.waddr = i2cmwr_pkg::MEM_AW'(r_byte_offset - ONE_C);
                                    req.wdata = i_item.data_byte;
                                end
                                off_rx        = r_byte_offset + ONE_C;
                                n_byte_offset = off_rx;
                            end
                            rx_phase = 1'b1;
                        end
                        i2cmwr_pkg::ST_RX_ADDR_ACK: begin
                            rx_phase = 1'b1;
                        end
                        i2cmwr_pkg::ST_RX_DATA_NACK: begin
                            n_recv_total = r_byte_offset;
                            if (r_byte_offset < FRAME_LEN_C) begin
                                if (r_byte_offset == '0) begin
                                    n_addr_byte = i_item.data_byte;
                                end else begin
                                    req.we    = 1'b1;
                                    req.waddr = i2cmwr_pkg::MEM_AW'(r_byte_offset - ONE_C);
                                    req.wdata = i_item.data_byte;
                                end
                            end
                            res.tx_byte  = i2cmwr_pkg::IDLE_BYTE;
                            res.tx_valid = 1'b1;
                            res.command  = i2cmwr_pkg::CMD_STOP;
                            res.done     = 1'b1;
                            n_busy       = 1'b0;
                        end
                        default: begin
                            // NACK, bus error or a code we do not know
                            n_recv_total = '0;
                            res.tx_byte  = i2cmwr_pkg::IDLE_BYTE;
                            res.tx_valid = 1'b1;
                            res.command  = i2cmwr_pkg::CMD_ABORT;
                            res.done     = 1'b1;
                            n_busy       = 1'b0;
                        end
                    endcase

                    if (tx_phase) begin
                        n_byte_offset = off_tx;
                        if (off_tx < r_send_total && off_tx < FRAME_LEN_C) begin
                            if (off_tx == '0) begin
                                res.tx_byte = r_addr_byte;
                            end else begin
                                res.tx_from_mem = 1'b1;
                                req.re          = 1'b1;
                                req.raddr       = i2cmwr_pkg::MEM_AW'(off_tx - ONE_C);
                            end
                            res.tx_valid  = 1'b1;
                            n_byte_offset = off_tx + ONE_C;
                            res.command   = i2cmwr_pkg::CMD_XFER;
                        end else if (r_recv_total != ONE_C) begin
                            // write phase over, repeated start into read
                            n_addr_byte = {r_addr_byte[7:1], 1'b1};
                            res.command = i2cmwr_pkg::CMD_START;
                        end else begin
                            res.tx_byte  = i2cmwr_pkg::IDLE_BYTE;
                            res.tx_valid = 1'b1;
                            res.command  = i2cmwr_pkg::CMD_STOP;
                            res.done     = 1'b1;
                            n_busy       = 1'b0;
                        end
                    end

                    if (rx_phase) begin
                        if ({1'b0, off_rx} + (OFF_W + 1)'(1) < {1'b0, r_recv_total}) begin
                            res.command = i2cmwr_pkg::CMD_ACK;
                        end else begin
                            res.command = i2cmwr_pkg::CMD_NACK;
                        end
                    end
                end
            end
            i2cmwr_pkg::KIND_READ: begin
                res.received_count = n_cnt;
                if ({1'b0, i_item.index} < n_cnt) begin
                    res.rx_from_mem = 1'b1;
                    req.re          = 1'b1;
                    req.raddr       = i_item.index;
                end
            end
            default: begin
            end
        endcase

        res.busy = n_busy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_offset <= '0;
            r_send_total  <= '0;
            r_recv_total  <= '0;
            r_busy        <= 1'b0;
        end else if (i_fire) begin
            r_byte_offset <= n_byte_offset;
            r_send_total  <= n_send_total;
            r_recv_total  <= n_recv_total;
            r_busy        <= n_busy;
        end
    end

    // address byte is frame entry 0; undefined until a start writes it
    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_addr_byte <= n_addr_byte;
        end
    end

    always_comb begin
        o_mem_req    = req;
        o_mem_req.we = req.we & i_fire;
        o_mem_req.re = req.re & i_fire;
    end

    assign o_result = res;

    a_offset_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_offset <= FRAME_LEN_C)
        else $error("byte offset past frame end");

    a_busy_totals: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_send_total != '0 && r_send_total <= FRAME_LEN_C))
        else $error("busy without a valid send total");

endmodule

// ----- tb/tb_i2c_master_write_read_sequencer.sv -----
module tb_i2c_master_write_read_sequencer;
    import i2cmwr_pkg::*;

    // Everything the block reports for one item, in compare order.
    typedef struct packed {
        t_cmd       command;
        logic [7:0] tx_byte;
        logic       tx_valid;
        logic       done;
        logic       busy;
        logic [7:0] rx_byte;
        logic [4:0] rx_count;
    } t_bus_reply;

    // One directed row: the item, and a hand-typed reply where it is obvious.
    typedef struct packed {
        t_item      stim;
        logic       typed;
        t_bus_reply want;
    } t_row;

    localparam int QUIET_LIMIT = 2000;   // cycles with no handshake on either side
    localparam int HOLD_CYCLES = 40;     // long receiver hold-off
    localparam int ITEM_TARGET = 1450;   // random items that do something
    localparam int TAIL_START  = 1250;   // no idling past this point

    localparam t_bus_reply QUIET_IDLE = '{CMD_NONE, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 5'd0};
    localparam t_bus_reply QUIET_BUSY = '{CMD_NONE, 8'h00, 1'b0, 1'b0, 1'b1, 8'h00, 5'd0};
    localparam t_bus_reply START_BUSY = '{CMD_START, 8'h00, 1'b0, 1'b0, 1'b1, 8'h00, 5'd0};
    localparam t_bus_reply STOP_DONE  = '{CMD_STOP, IDLE_BYTE, 1'b1, 1'b1, 1'b0, 8'h00, 5'd0};
    localparam t_bus_reply ABORT_DONE = '{CMD_ABORT, IDLE_BYTE, 1'b1, 1'b1, 1'b0, 8'h00, 5'd0};
    localparam t_bus_reply PREDICT    = '0;

    // Directed walk: idle corner cases, a full write-then-read with an
    // arbitration loss, a zero/zero transfer, an abort, and read-backs.
    // Fields: kind, index, data, address, send count, recv count, status.
    localparam t_row DIRECTED [27] = '{
        // read-back and a bus event right after reset: nothing happens
        '{'{KIND_READ,   4'd0,  8'h00, 7'h00, 8'd0,   8'd255, 8'h00}, 1'b1, QUIET_IDLE},
        '{'{KIND_STATUS, 4'd0,  8'h00, 7'h00, 8'd0,   8'd0,   ST_START}, 1'b1, QUIET_IDLE},
        // fill data bytes 0, 1 and the last slot
        '{'{KIND_LOAD,   4'd0,  8'hA5, 7'h00, 8'd0,   8'd0,   8'h00}, 1'b1, QUIET_IDLE},
        '{'{KIND_LOAD,   4'd1,  8'h00, 7'h00, 8'd0,   8'd0,   8'h00}, 1'b1, QUIET_IDLE},
        '{'{KIND_LOAD,   4'd15, 8'hFF, 7'h00, 8'd0,   8'd0,   8'h00}, 1'b1, QUIET_IDLE},
        // write two, read three, top address
        '{'{KIND_START,  4'd0,  8'h00, 7'h7F, 8'd2,   8'd3,   8'h00}, 1'b1, START_BUSY},
        // start and load while busy are dropped
        '{'{KIND_START,  4'd0,  8'h00, 7'h00, 8'd0,   8'd0,   8'h00}, 1'b1, QUIET_BUSY},
        '{'{KIND_LOAD,   4'd2,  8'h11, 7'h00, 8'd0,   8'd0,   8'h00}, 1'b1, QUIET_BUSY},
        '{'{KIND_STATUS, 4'd0,  8'h00, 7'h00, 8'd0,   8'd0,   ST_START}, 1'b0, PREDICT},
        '{'{KIND_STATUS, 4'd0,  8'h00, 7'h00, 8'd0,   8'd0,   ST_ARB_LOST}, 1'b1, START_BUSY},
        '{'{KIND_STATUS, 4'd0,  8'h00, 7'h00, 8'd0,   8'd0,   ST_REP_START}, 1'b0, PREDICT},
        '{'{KIND_STATUS, 4'd0,  8'h00, 7'h00, 8'd0,   8'd0,   ST_TX_ADDR_ACK}, 1'b0, PREDICT},
        '{'{KIND_STATUS, 4'd0,  8'h00, 7'h00, 8'd0,   8'd0,   ST_TX_DATA_ACK}, 1'b0, PREDICT},
        '{'{KIND_STATUS, 4'd0,  8'h00, 7'h00, 8'd0,   8'd0,   ST_TX_DATA_ACK}, 1'b0, PREDICT},
        // read phase
        '{'{KIND_STATUS, 4'd0,  8'h00, 7'h00, 8'd0,   8'd0,   ST_REP_START}, 1'b0, PREDICT},
        '{'{KIND_STATUS, 4'd0,  8'h00, 7'h00, 8'd0,   8'd0,   ST_RX_ADDR_ACK}, 1'b0, PREDICT},
        '{'{KIND_STATUS, 4'd0,  8'h3C, 7'h00, 8'd0,   8'd0,   ST_RX_DATA_ACK}, 1'b0, PREDICT},
        '{'{KIND_STATUS, 4'd0,  8'hC3, 7'h00, 8'd0,   8'd0,   ST_RX_DATA_ACK}, 1'b0, PREDICT},
        '{'{KIND_STATUS, 4'd0,  8'h5A, 7'h00, 8'd0,   8'd0,   ST_RX_DATA_NACK}, 1'b1, STOP_DONE},
        '{'{KIND_READ,   4'd2,  8'h00, 7'h00, 8'd0,   8'd255, 8'h00}, 1'b0, PREDICT},
        '{'{KIND_READ,   4'd15, 8'h00, 7'h00, 8'd0,   8'd0,   8'h00}, 1'b1, QUIET_IDLE},
        // nothing to send or read: address with read bit, then stop
        '{'{KIND_START,  4'd0,  8'h00, 7'h00, 8'd0,   8'd0,   8'h00}, 1'b1, START_BUSY},
        '{'{KIND_STATUS, 4'd0,  8'h00, 7'h00, 8'd0,   8'd0,   ST_START}, 1'b0, PREDICT},
        '{'{KIND_STATUS, 4'd0,  8'h00, 7'h00, 8'd0,   8'd0,   ST_TX_ADDR_ACK}, 1'b1, STOP_DONE},
        // saturated receive count, then an unknown status aborts
        '{'{KIND_START,  4'd0,  8'h00, 7'h55, 8'd1,   8'd255, 8'h00}, 1'b1, START_BUSY},
        '{'{KIND_STATUS, 4'd0,  8'h00, 7'h00, 8'd0,   8'd0,   8'hFF}, 1'b1, ABORT_DONE},
        // abort leaves nothing to read back
        '{'{KIND_READ,   4'd0,  8'h00, 7'h00, 8'd0,   8'd255, 8'h00}, 1'b1, QUIET_IDLE}
    };

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic [1:0] i_kind = '0;
    logic [3:0] i_index = '0;
    logic [7:0] i_data_byte = '0;
    logic [6:0] i_slave_address = '0;
    logic [7:0] i_send_count = '0;
    logic [7:0] i_recv_count = '0;
    logic [7:0] i_status_code = '0;
    logic       i_out_stall = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [2:0] o_command;
    logic [7:0] o_tx_byte;
    logic       o_tx_valid;
    logic       o_done_res;
    logic       o_busy_res;
    logic [7:0] o_rx_byte;
    logic [4:0] o_received_count;

    i2c_master_write_read_sequencer uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_kind          (i_kind),
        .i_index         (i_index),
        .i_data_byte     (i_data_byte),
        .i_slave_address (i_slave_address),
        .i_send_count    (i_send_count),
        .i_recv_count    (i_recv_count),
        .i_status_code   (i_status_code),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_command       (o_command),
        .o_tx_byte       (o_tx_byte),
        .o_tx_valid      (o_tx_valid),
        .o_done_res      (o_done_res),
        .o_busy_res      (o_busy_res),
        .o_rx_byte       (o_rx_byte),
        .o_received_count(o_received_count)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Sequencer shadow: frame buffer, offset, totals, busy.
    // written[] marks frame entries that hold a real value; entry 0 is
    // always set by a start before anything reads it.
    // ---------------------------------------------------------------
    logic [7:0] frame   [FRAME_LEN];
    bit         written [FRAME_LEN];
    logic [4:0] pos;
    logic [4:0] tx_len;
    logic [4:0] rx_len;
    logic       busy;
    t_cmd       bus_cmd;          // last bus command, drives the next status

    t_bus_reply pending_replies [$];
    int         mismatch_count;
    int         good_items;       // random items the block does not drop
    bit         counting;
    bit         idle_on;
    bit         hold_req;

    initial begin
        foreach (written[k]) written[k] = 1'b0;
        pos = '0;
        tx_len = '0;
        rx_len = '0;
        busy = 1'b0;
        bus_cmd = CMD_NONE;
        mismatch_count = 0;
        good_items = 0;
        counting = 1'b0;
        idle_on = 1'b0;
        hold_req = 1'b0;
    end

    function automatic logic [4:0] sat16(logic [7:0] v);
        return (v > 8'(BUFFER_BYTES)) ? 5'(BUFFER_BYTES) : v[4:0];
    endfunction

    function automatic void advance();
        if (pos < 5'(FRAME_LEN)) pos = pos + 5'd1;
    endfunction

    function automatic void keep_rx(logic [7:0] b);
        if (pos < 5'(FRAME_LEN)) begin
            frame[pos] = b;
            written[pos] = 1'b1;
        end
    endfunction

    // Advances the shadow by one item and returns the reply it owes.
    function automatic t_bus_reply step_sequencer(t_item it);
        t_bus_reply r;
        logic [4:0] s;
        logic [4:0] n;
        logic [4:0] slot;
        bit         tx_ph;
        bit         rx_ph;
        r = '0;
        tx_ph = 1'b0;
        rx_ph = 1'b0;
        slot = {1'b0, it.index} + 5'd1;
        case (it.kind)
            KIND_LOAD: begin
                if (!busy) begin
                    frame[slot] = it.data_byte;
                    written[slot] = 1'b1;
                end
            end
            KIND_START: begin
                if (!busy) begin
                    s = sat16(it.send_count);
                    frame[0] = {it.slave_address, s == 5'd0};
                    tx_len = s + 5'd1;
                    rx_len = sat16(it.recv_count) + 5'd1;
                    busy = 1'b1;
                    r.command = CMD_START;
                end
            end
            KIND_STATUS: begin
                if (busy) begin
                    case (it.status_code)
                        ST_START, ST_REP_START: begin
                            pos = '0;
                            tx_ph = 1'b1;
                        end
                        ST_TX_ADDR_ACK, ST_TX_DATA_ACK: tx_ph = 1'b1;
                        ST_ARB_LOST: begin
                            // retry keeps the write direction unless nothing is sent
                            if (tx_len != 5'd1) frame[0][0] = 1'b0;
                            r.command = CMD_START;
                        end
                        ST_RX_DATA_ACK: begin
                            keep_rx(it.data_byte);
                            advance();
                            rx_ph = 1'b1;
                        end
                        ST_RX_ADDR_ACK: rx_ph = 1'b1;
                        ST_RX_DATA_NACK: begin
                            rx_len = pos;
                            keep_rx(it.data_byte);
                            r = STOP_DONE;
                            busy = 1'b0;
                        end
                        default: begin
                            // NACK, bus error, anything unknown
                            rx_len = '0;
                            r = ABORT_DONE;
                            busy = 1'b0;
                        end
                    endcase
                    if (tx_ph) begin
                        if (pos < tx_len && pos < 5'(FRAME_LEN)) begin
                            r.tx_byte = frame[pos];
                            r.tx_valid = 1'b1;
                            r.command = CMD_XFER;
                            advance();
                        end else if (rx_len != 5'd1) begin
                            frame[0][0] = 1'b1;   // turn around into the read
                            r.command = CMD_START;
                        end else begin
                            r = STOP_DONE;
                            busy = 1'b0;
                        end
                    end
                    if (rx_ph) r.command = (pos + 5'd1 < rx_len) ? CMD_ACK : CMD_NACK;
                end
            end
            default: begin
                n = sat16(it.recv_count);
                if (rx_len < n) n = rx_len;
                r.rx_count = n;
                if ({1'b0, it.index} < n && slot < 5'(FRAME_LEN)) r.rx_byte = frame[slot];
            end
        endcase
        r.busy = busy;
        if ((it.kind == KIND_START || it.kind == KIND_STATUS) && r.command != CMD_NONE)
            bus_cmd = r.command;
        return r;
    endfunction

    // First data slot (1..s) that was never written, 0 when all are.
    function automatic logic [4:0] first_gap(logic [4:0] s);
        for (int k = 1; k <= int'(s); k++) begin
            if (!written[k]) return 5'(k);
        end
        return 5'd0;
    endfunction

    // Keeps random items off never-written frame entries.
    function automatic t_item made_safe(t_item it);
        logic [4:0] gap;
        logic [4:0] n;
        if (it.kind == KIND_START && !busy) begin
            gap = first_gap(sat16(it.send_count));
            if (gap != 5'd0) begin
                it.kind = KIND_LOAD;
                it.index = 4'(gap - 5'd1);
            end
        end else if (it.kind == KIND_READ) begin
            n = sat16(it.recv_count);
            if (rx_len < n) n = rx_len;
            if ({1'b0, it.index} < n && !written[{1'b0, it.index} + 5'd1])
                it.recv_count = {4'd0, it.index};   // ask for no more bytes than the index
        end
        return it;
    endfunction

    function automatic t_item rand_item();
        t_item it;
        it.kind = t_kind'(2'($urandom_range(0, 3)));
        it.index = 4'($urandom_range(0, 15));
        it.data_byte = 8'($urandom_range(0, 255));
        it.slave_address = 7'($urandom_range(0, 127));
        it.send_count = 8'($urandom_range(0, 255));
        it.recv_count = 8'($urandom_range(0, 255));
        it.status_code = 8'($urandom_range(0, 255));
        return it;
    endfunction

    // Mostly short transfers, some up to the buffer size, a few saturating.
    function automatic logic [7:0] pick_count();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 14) return 8'($urandom_range(0, 4));
        if (sel < 17) return 8'($urandom_range(5, 16));
        return 8'($urandom_range(17, 255));
    endfunction

    // Drives one item, holds it until taken, then books its reply.
    task automatic send_item(t_item it, bit typed, t_bus_reply typed_want);
        t_bus_reply r;
        bit         live;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_kind          <= it.kind;
        i_index         <= it.index;
        i_data_byte     <= it.data_byte;
        i_slave_address <= it.slave_address;
        i_send_count    <= it.send_count;
        i_recv_count    <= it.recv_count;
        i_status_code   <= it.status_code;
        do @(posedge i_clk); while (o_in_stall);
        live = (it.kind == KIND_LOAD && !busy) || (it.kind == KIND_START && !busy) ||
               (it.kind == KIND_STATUS && busy) || it.kind == KIND_READ;
        if (counting && live) good_items++;
        r = step_sequencer(it);
        pending_replies.push_back(typed ? typed_want : r);
    endtask

    task automatic send_random(t_item it);
        send_item(made_safe(it), 1'b0, PREDICT);
    endtask

    // One write-then-read on the bus, with some noise and broken steps.
    task automatic run_transaction();
        t_item      it;
        logic [7:0] sc;
        logic [7:0] rc;
        logic [4:0] gap;
        int         sel;
        int         steps;
        repeat ($urandom_range(0, 3)) begin
            it = rand_item();
            it.kind = KIND_LOAD;
            send_random(it);
        end
        sc = pick_count();
        rc = pick_count();
        gap = first_gap(sat16(sc));
        while (gap != 5'd0) begin
            it = rand_item();
            it.kind = KIND_LOAD;
            it.index = 4'(gap - 5'd1);
            send_random(it);
            gap = first_gap(sat16(sc));
        end
        it = rand_item();
        it.kind = KIND_START;
        it.send_count = sc;
        it.recv_count = rc;
        send_random(it);
        steps = 0;
        while (busy && steps < 60) begin
            it = rand_item();
            sel = $urandom_range(0, 99);
            if (sel < 4) begin
                // fully random item, usually dropped
            end else if (sel < 7) begin
                it.kind = KIND_READ;
            end else begin
                it.kind = KIND_STATUS;
                if (sel < 9) it.status_code = ST_ARB_LOST;
                else if (sel >= 11) begin
                    case (bus_cmd)
                        CMD_START: it.status_code = $urandom_range(0, 1) ? ST_START
                                                                         : ST_REP_START;
                        CMD_XFER: begin
                            if (pos == 5'd1)
                                it.status_code = frame[0][0] ? ST_RX_ADDR_ACK : ST_TX_ADDR_ACK;
                            else
                                it.status_code = ST_TX_DATA_ACK;
                        end
                        CMD_ACK:  it.status_code = ST_RX_DATA_ACK;
                        // an occasional extra byte pushes past the buffer end
                        CMD_NACK: it.status_code = ($urandom_range(0, 9) == 0) ? ST_RX_DATA_ACK
                                                                             : ST_RX_DATA_NACK;
                        default:  it.status_code = ST_START;
                    endcase
                end
            end
            send_random(it);
            steps++;
        end
        if (busy) begin
            it = rand_item();
            it.kind = KIND_STATUS;
            it.status_code = 8'h00;    // bus error ends a runaway transaction
            send_random(it);
        end
        repeat ($urandom_range(0, 2)) begin
            it = rand_item();
            it.kind = KIND_READ;
            send_random(it);
        end
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch on %s: got %0h, want %0h", what, got, want);
        mismatch_count++;
    endtask

    // ---------------------------------------------------------------
    // Result side: random stall bursts, plus a long hold-off on request.
    // ---------------------------------------------------------------
    int hold_left = 0;
    int burst_left = 0;

    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (burst_left > 0) begin
            burst_left--;
            i_out_stall <= 1'b1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            burst_left = $urandom_range(0, 4);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Each result taken is checked against the oldest booked reply.
    always @(posedge i_clk) begin
        t_bus_reply seen;
        t_bus_reply want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen = '{t_cmd'(o_command), o_tx_byte, o_tx_valid, o_done_res, o_busy_res,
                     o_rx_byte, o_received_count};
            if (pending_replies.size() == 0) begin
                report_mismatch("unexpected result, command", int'(seen.command), 0);
            end else begin
                want = pending_replies.pop_front();
                if (seen.command !== want.command)
                    report_mismatch("command", int'(seen.command), int'(want.command));
                if (seen.tx_byte !== want.tx_byte)
                    report_mismatch("tx_byte", int'(seen.tx_byte), int'(want.tx_byte));
                if (seen.tx_valid !== want.tx_valid)
                    report_mismatch("tx_valid", int'(seen.tx_valid), int'(want.tx_valid));
                if (seen.done !== want.done)
                    report_mismatch("done", int'(seen.done), int'(want.done));
                if (seen.busy !== want.busy)
                    report_mismatch("busy", int'(seen.busy), int'(want.busy));
                if (seen.rx_byte !== want.rx_byte)
                    report_mismatch("rx_byte", int'(seen.rx_byte), int'(want.rx_byte));
                if (seen.rx_count !== want.rx_count)
                    report_mismatch("received_count", int'(seen.rx_count),
                                    int'(want.rx_count));
            end
        end
    end

    // Watchdog: too long without a handshake on either side.
    int quiet = 0;

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        int trans;
        trans = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED[i]) send_item(DIRECTED[i].stim, DIRECTED[i].typed, DIRECTED[i].want);

        counting = 1'b1;
        while (good_items < ITEM_TARGET) begin
            idle_on = (good_items < TAIL_START) && ($urandom_range(0, 3) != 0);
            if (trans == 30) begin
                // receiver sits still while items keep coming: input must back up
                idle_on = 1'b0;
                hold_req = 1'b1;
            end
            if (trans == 60) begin
                // sender waits for every booked reply before going on
                i_in_valid <= 1'b0;
                while (pending_replies.size() != 0) @(posedge i_clk);
                @(posedge i_clk);
            end
            run_transaction();
            trans++;
        end

        idle_on = 1'b0;
        i_in_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && pending_replies.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
